FILE: sv/scalar_mod_l_reduce_assert.svh
// Assertion macros used by the scalar reduction checker, smlr_checker.
// Depends on clk and rst_n being visible where a macro is used.
`ifndef SCALAR_MOD_L_REDUCE_ASSERT_SVH
`define SCALAR_MOD_L_REDUCE_ASSERT_SVH

// same-cycle implication
`define SMLR_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scalar reduce check failed");

// next-cycle implication
`define SMLR_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scalar reduce check failed");

`endif

FILE: sv/smlr_pkg.sv
// Package for the scalar reduction mod L: limb types, fold constants
// and the combinational step functions of each pipeline stage. No dependencies.
package smlr_pkg;

    localparam int LIMB_BITS  = 21;
    localparam int LIMB_COUNT = 24;
    localparam int LIMB_W     = 56;
    localparam int T_W        = 32;
    localparam int K_W        = 21;
    localparam int P_W        = T_W + K_W;
    localparam int STAGES     = 8;

    typedef logic signed [LIMB_W-1:0] limb_t;
    typedef limb_t limbs_t [LIMB_COUNT];
    typedef logic signed [T_W-1:0] fold_t;
    typedef logic signed [P_W-1:0] prod_t;

    localparam logic signed [K_W-1:0] K0 = 21'sd666643;
    localparam logic signed [K_W-1:0] K1 = 21'sd470296;
    localparam logic signed [K_W-1:0] K2 = 21'sd654183;
    localparam logic signed [K_W-1:0] K3 = 21'sd997805;
    localparam logic signed [K_W-1:0] K4 = 21'sd136657;
    localparam logic signed [K_W-1:0] K5 = 21'sd683901;

    localparam limb_t HALF = limb_t'(1) <<< (LIMB_BITS - 1);

    function automatic limbs_t fold(input limbs_t s, input int hi);
        limbs_t r;
        fold_t  t;
        prod_t  p0, p1, p2, p3, p4, p5;
        r  = s;
        t  = s[hi][T_W-1:0];
        p0 = t * K0;
        p1 = t * K1;
        p2 = t * K2;
        p3 = t * K3;
        p4 = t * K4;
        p5 = t * K5;
        r[hi-12] = r[hi-12] + limb_t'(p0);
        r[hi-11] = r[hi-11] + limb_t'(p1);
        r[hi-10] = r[hi-10] + limb_t'(p2);
        r[hi-9]  = r[hi-9]  - limb_t'(p3);
        r[hi-8]  = r[hi-8]  + limb_t'(p4);
        r[hi-7]  = r[hi-7]  - limb_t'(p5);
        return r;
    endfunction

    function automatic limbs_t carry_rnd(input limbs_t s, input int i);
        limbs_t r;
        limb_t  c;
        r = s;
        c = (s[i] + HALF) >>> LIMB_BITS;
        r[i+1] = r[i+1] + c;
        r[i]   = r[i] - (c <<< LIMB_BITS);
        return r;
    endfunction

    function automatic limbs_t carry_ext(input limbs_t s, input int i);
        limbs_t r;
        limb_t  c;
        r = s;
        c = s[i] >>> LIMB_BITS;
        r[i+1] = r[i+1] + c;
        r[i]   = r[i] - (c <<< LIMB_BITS);
        return r;
    endfunction

    function automatic limbs_t step0(input logic [511:0] v);
        limbs_t s;
        for (int i = 0; i < LIMB_COUNT - 1; i++)
        begin
            s[i] = limb_t'({1'b0, v[i*LIMB_BITS +: LIMB_BITS]});
        end
        s[LIMB_COUNT-1] = limb_t'({1'b0, v[511:483]});
        for (int h = 23; h >= 18; h--)
        begin
            s = fold(s, h);
        end
        return s;
    endfunction

    function automatic limbs_t step1(input limbs_t a);
        limbs_t s;
        s = a;
        for (int i = 6; i <= 16; i += 2)
        begin
            s = carry_rnd(s, i);
        end
        for (int i = 7; i <= 15; i += 2)
        begin
            s = carry_rnd(s, i);
        end
        return s;
    endfunction

    function automatic limbs_t step2(input limbs_t a);
        limbs_t s;
        s = a;
        for (int h = 17; h >= 12; h--)
        begin
            s = fold(s, h);
        end
        s[12] = '0;
        return s;
    endfunction

    function automatic limbs_t step3(input limbs_t a);
        limbs_t s;
        s = a;
        for (int i = 0; i <= 10; i += 2)
        begin
            s = carry_rnd(s, i);
        end
        for (int i = 1; i <= 11; i += 2)
        begin
            s = carry_rnd(s, i);
        end
        return s;
    endfunction

    function automatic limbs_t step4(input limbs_t a);
        limbs_t s;
        s = fold(a, 12);
        s[12] = '0;
        for (int i = 0; i <= 5; i++)
        begin
            s = carry_ext(s, i);
        end
        return s;
    endfunction

    function automatic limbs_t step5(input limbs_t a);
        limbs_t s;
        s = a;
        for (int i = 6; i <= 11; i++)
        begin
            s = carry_ext(s, i);
        end
        return s;
    endfunction

    function automatic limbs_t step6(input limbs_t a);
        limbs_t s;
        s = fold(a, 12);
        for (int i = 0; i <= 4; i++)
        begin
            s = carry_ext(s, i);
        end
        return s;
    endfunction

    function automatic limbs_t step7(input limbs_t a);
        limbs_t s;
        s = a;
        for (int i = 5; i <= 10; i++)
        begin
            s = carry_ext(s, i);
        end
        return s;
    endfunction

endpackage

FILE: sv/scalar_mod_l_reduce.sv
// Top level of the scalar reduction mod the Ed25519 group order L.
// Depends on smlr_pkg for limb types and per-stage step functions.
//
// Reduces a 512-bit value to its residue mod L through an eight-stage
// pipeline: one item enters per cycle while in_stall is low, and its result
// shows from the last stage register. Each stage holds twenty-four
// signed limbs. Four of the stages fold high limbs down with 32x21 constant
// multiplies: six folds in the first and third stages, one in the fifth and
// seventh. No stage chains more than twelve limb carries. Stalls hold the
// pipeline back only as far as empty stages allow, so bubbles are squeezed out.
module scalar_mod_l_reduce
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] value_w0,
    input  logic [63:0] value_w1,
    input  logic [63:0] value_w2,
    input  logic [63:0] value_w3,
    input  logic [63:0] value_w4,
    input  logic [63:0] value_w5,
    input  logic [63:0] value_w6,
    input  logic [63:0] value_w7,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] reduced_w0,
    output logic [63:0] reduced_w1,
    output logic [63:0] reduced_w2,
    output logic [60:0] reduced_w3
);

    localparam int NS = smlr_pkg::STAGES;

    smlr_pkg::limbs_t data_reg [NS];
    smlr_pkg::limbs_t data_next [NS];
    logic [NS-1:0]    vld_reg;
    logic [NS:0]      adv;
    logic [255:0]     packed_res;

    always_comb
    begin
        adv[NS] = !out_stall;
        for (int k = NS - 1; k >= 0; k--)
        begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
    end

    assign in_stall = !adv[0];

    always_comb
    begin
        data_next[0] = smlr_pkg::step0({value_w7, value_w6, value_w5, value_w4,
                                        value_w3, value_w2, value_w1, value_w0});
        data_next[1] = smlr_pkg::step1(data_reg[0]);
        data_next[2] = smlr_pkg::step2(data_reg[1]);
        data_next[3] = smlr_pkg::step3(data_reg[2]);
        data_next[4] = smlr_pkg::step4(data_reg[3]);
        data_next[5] = smlr_pkg::step5(data_reg[4]);
        data_next[6] = smlr_pkg::step6(data_reg[5]);
        data_next[7] = smlr_pkg::step7(data_reg[6]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int k = 1; k < NS; k++)
            begin
                if (adv[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NS; k++)
        begin
            if (adv[k])
            begin
                data_reg[k] <= data_next[k];
            end
        end
    end

    always_comb
    begin
        packed_res = '0;
        for (int i = 0; i < 11; i++)
        begin
            packed_res[i*21 +: 21] = data_reg[NS-1][i][20:0];
        end
        packed_res[255:231] = data_reg[NS-1][11][24:0];
    end

    assign out_valid  = vld_reg[NS-1];
    assign reduced_w0 = packed_res[63:0];
    assign reduced_w1 = packed_res[127:64];
    assign reduced_w2 = packed_res[191:128];
    assign reduced_w3 = packed_res[252:192];

endmodule

FILE: sv/smlr_checker.sv
// Port-level checker for scalar_mod_l_reduce, bound to the top level.
// Depends on scalar_mod_l_reduce_assert.svh for the assertion macros.
`include "scalar_mod_l_reduce_assert.svh"

module smlr_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [63:0] reduced_w0,
    input logic [60:0] reduced_w3
);

    `SMLR_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid)
    `SMLR_ASSERT_NXT(a_out_stable, out_valid && out_stall, $stable(reduced_w0))
    `SMLR_ASSERT_NOW(a_below_l, out_valid, !reduced_w3[60] || reduced_w3[59:0] == 60'd0)
    `SMLR_ASSERT_NOW(a_no_stall_idle, !out_valid, !in_stall)

endmodule

bind scalar_mod_l_reduce smlr_checker u_smlr_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .reduced_w0 (reduced_w0),
    .reduced_w3 (reduced_w3)
);

FILE: tb/scalar_mod_l_reduce_test.sv
// Self-checking testbench for scalar_mod_l_reduce: drives 512-bit values with
// random gaps and stalls, and checks each residue against a modulo-L predictor.
// Depends only on the scalar_mod_l_reduce RTL and its package.
module scalar_mod_l_reduce_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [511:0] GROUP_L =
        512'h1000000000000000000000000000000014def9dea2f79cd65812631a5cf5d3ed;
    localparam int CYCLE_LIMIT = 400000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [63:0] value_w0, value_w1, value_w2, value_w3;
    logic [63:0] value_w4, value_w5, value_w6, value_w7;
    logic        out_valid;
    logic        out_stall;
    logic [63:0] reduced_w0, reduced_w1, reduced_w2;
    logic [60:0] reduced_w3;

    logic [511:0] pending_values [$];
    logic [255:0] expected_residues [$];
    int           error_count;
    int           cycle_count;
    int           send_gap;
    int           stall_left;
    bit           input_taken;
    bit           stimulus_done;

    scalar_mod_l_reduce dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .value_w0   (value_w0),
        .value_w1   (value_w1),
        .value_w2   (value_w2),
        .value_w3   (value_w3),
        .value_w4   (value_w4),
        .value_w5   (value_w5),
        .value_w6   (value_w6),
        .value_w7   (value_w7),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .reduced_w0 (reduced_w0),
        .reduced_w1 (reduced_w1),
        .reduced_w2 (reduced_w2),
        .reduced_w3 (reduced_w3)
    );

    function automatic logic [255:0] residue_mod_l(input logic [511:0] v);
        logic [511:0] r;
        r = v % GROUP_L;
        return r[255:0];
    endfunction

    function automatic logic [511:0] random_wide();
        logic [511:0] v;
        for (int i = 0; i < 16; i++)
        begin
            v[i*32 +: 32] = $urandom;
        end
        return v;
    endfunction

    function automatic int random_gap();
        if ($urandom_range(0, 9) < 5)
        begin
            return 0;
        end
        if ($urandom_range(0, 9) < 8)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h want %h", field, got, want);
        error_count++;
    endtask

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        out_stall = 1'b0;
        {value_w7, value_w6, value_w5, value_w4} = '0;
        {value_w3, value_w2, value_w1, value_w0} = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[scalar_mod_l_reduce] ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        input_taken <= 1'b0;
        if (rst_n && in_valid && !in_stall)
        begin
            expected_residues.push_back(residue_mod_l({value_w7, value_w6, value_w5,
                value_w4, value_w3, value_w2, value_w1, value_w0}));
            input_taken <= 1'b1;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || input_taken))
        begin
            if (send_gap > 0 || pending_values.size() == 0)
            begin
                in_valid <= 1'b0;
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                end
            end
            else
            begin
                logic [511:0] v;
                v = pending_values.pop_front();
                {value_w7, value_w6, value_w5, value_w4} <= v[511:256];
                {value_w3, value_w2, value_w1, value_w0} <= v[255:0];
                in_valid <= 1'b1;
                send_gap <= random_gap();
            end
        end
    end

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (rst_n && $urandom_range(0, 3) == 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= random_gap();
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_residues.size() == 0)
            begin
                report_mismatch("unexpected item", reduced_w0, '0);
            end
            else
            begin
                logic [255:0] want;
                want = expected_residues.pop_front();
                if (reduced_w0 !== want[63:0])
                    report_mismatch("reduced_w0", reduced_w0, want[63:0]);
                if (reduced_w1 !== want[127:64])
                    report_mismatch("reduced_w1", reduced_w1, want[127:64]);
                if (reduced_w2 !== want[191:128])
                    report_mismatch("reduced_w2", reduced_w2, want[191:128]);
                if (reduced_w3 !== want[252:192])
                    report_mismatch("reduced_w3", {3'b0, reduced_w3},
                                    {3'b0, want[252:192]});
            end
        end
    end

    initial
    begin
        logic [511:0] v;
        logic [511:0] k;
        error_count = 0;
        cycle_count = 0;
        send_gap    = 0;
        stall_left  = 0;
        input_taken = 1'b0;

        pending_values.push_back('0);
        pending_values.push_back('1);
        pending_values.push_back(512'd1);
        pending_values.push_back(GROUP_L - 1);
        pending_values.push_back(GROUP_L);
        pending_values.push_back(GROUP_L + 1);
        pending_values.push_back(GROUP_L * 2);
        pending_values.push_back(512'd1 << 252);
        pending_values.push_back(512'd1 << 511);
        pending_values.push_back(512'd1 << 483);
        pending_values.push_back((512'd1 << 264) - 1);
        pending_values.push_back((512'd1 << 256) - 1);
        pending_values.push_back({16{32'haaaa5555}});
        pending_values.push_back({16{32'h5555aaaa}});
        pending_values.push_back('1 - GROUP_L);
        pending_values.push_back(GROUP_L * ((512'd1 << 256) - 1));
        pending_values.push_back(GROUP_L * ((512'd1 << 258) - 1) + GROUP_L - 1);
        pending_values.push_back(random_wide() & ((512'd1 << 264) - 1));

        for (int n = 0; n < 1200; n++)
        begin
            v = random_wide();
            case ($urandom_range(0, 5))
                0: v = v & ((512'd1 << 264) - 1);
                1:
                begin
                    k = random_wide() & ((512'd1 << 258) - 1);
                    v = GROUP_L * k + (v & 512'hff) - 512'h80;
                end
                2:
                begin
                    for (int w = 0; w < 8; w++)
                    begin
                        if ($urandom_range(0, 1))
                            v[w*64 +: 64] = $urandom_range(0, 1) ? '1 : '0;
                    end
                end
                3: v = v & ((512'd1 << $urandom_range(1, 511)) - 1);
                default: ;
            endcase
            pending_values.push_back(v);
        end

        wait (rst_n);
        while (pending_values.size() != 0 || in_valid || expected_residues.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (30) @(posedge clk);
        if (error_count == 0)
        begin
            $display("[scalar_mod_l_reduce] OK");
        end
        else
        begin
            $display("[scalar_mod_l_reduce] ERROR");
        end
        $finish;
    end
endmodule

FILE: sim.f
+incdir+sv
sv/smlr_pkg.sv
sv/scalar_mod_l_reduce.sv
sv/smlr_checker.sv
tb/scalar_mod_l_reduce_test.sv
